// File: src/u8u16_pkg.sv
package u8u16_pkg;

  localparam int QueueDepth = 2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  localparam logic [7:0] BOM_LO = 8'hFF;
  localparam logic [7:0] BOM_HI = 8'hFE;

  // up to four output bytes made by one input byte; status and last belong to the final one
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    logic [1:0]      status;
    logic            last;
  } cmd_t;

endpackage

// File: src/u8u16_front.sv
module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              output_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output logic              push,
  output u8u16_pkg::cmd_t   push_cmd,
  input  logic              q_full
);

  logic        mode;
  logic        bom_pending, bom_pending_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic [20:0] code_acc, code_acc_next;
  logic        discarding, discarding_next;

  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    logic [2:0]  n;
    logic        err;
    logic [1:0]  err_status;
    logic [20:0] acc;
    logic [20:0] cp;
    logic [20:0] s;
    logic        overlong;
    logic        eot;

    n          = 3'd0;
    err        = 1'b0;
    err_status = u8u16_pkg::STATUS_OK;
    acc        = '0;
    cp         = '0;
    s          = '0;
    overlong   = 1'b0;
    eot        = end_of_text;

    bom_pending_next     = bom_pending;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    code_acc_next        = code_acc;
    discarding_next      = discarding;

    push_cmd        = '0;
    push_cmd.status = u8u16_pkg::STATUS_OK;

    if (!mode) begin
      bytes_remaining_next = '0;
      sequence_length_next = '0;
      code_acc_next        = '0;
      discarding_next      = 1'b0;
      if (eot) bom_pending_next = 1'b1;
      push_cmd.bytes[0] = in_byte;
      push_cmd.last     = eot;
      n                 = 3'd1;
    end else if (discarding) begin
      if (eot) begin
        discarding_next      = 1'b0;
        bom_pending_next     = 1'b1;
        bytes_remaining_next = '0;
        sequence_length_next = '0;
        code_acc_next        = '0;
      end
    end else begin
      if (bom_pending) begin
        push_cmd.bytes[0] = u8u16_pkg::BOM_LO;
        push_cmd.bytes[1] = u8u16_pkg::BOM_HI;
        n                 = 3'd2;
        bom_pending_next  = 1'b0;
      end

      if (bytes_remaining == 2'd0) begin
        if (!in_byte[7]) begin
          push_cmd.bytes[n[1:0]]        = in_byte;
          push_cmd.bytes[n[1:0] + 2'd1] = 8'h00;
          n                             = n + 3'd2;
          push_cmd.last                 = eot;
          if (eot) bom_pending_next = 1'b1;
        end else begin
          if (in_byte[7:5] == 3'b110) begin
            sequence_length_next = 3'd2;
            bytes_remaining_next = 2'd1;
            code_acc_next        = {16'd0, in_byte[4:0]};
          end else if (in_byte[7:4] == 4'b1110) begin
            sequence_length_next = 3'd3;
            bytes_remaining_next = 2'd2;
            code_acc_next        = {17'd0, in_byte[3:0]};
          end else if (in_byte[7:3] == 5'b11110) begin
            sequence_length_next = 3'd4;
            bytes_remaining_next = 2'd3;
            code_acc_next        = {18'd0, in_byte[2:0]};
          end else begin
            err        = 1'b1;
            err_status = u8u16_pkg::STATUS_INVALID;
          end
          if (!err && eot) begin
            err        = 1'b1;
            err_status = u8u16_pkg::STATUS_TRUNC;
          end
        end
      end else begin
        if (eot && bytes_remaining > 2'd1) begin
          err        = 1'b1;
          err_status = u8u16_pkg::STATUS_TRUNC;
        end else if (in_byte[7:6] != 2'b10) begin
          err        = 1'b1;
          err_status = u8u16_pkg::STATUS_INVALID;
        end else begin
          acc                  = {code_acc[14:0], in_byte[5:0]};
          code_acc_next        = acc;
          bytes_remaining_next = bytes_remaining - 2'd1;
          if (bytes_remaining == 2'd1) begin
            cp       = acc;
            overlong = (sequence_length == 3'd2 && cp < 21'h80)
                    || (sequence_length == 3'd3 && cp < 21'h800)
                    || (sequence_length == 3'd4 && cp < 21'h10000);
            bytes_remaining_next = '0;
            sequence_length_next = '0;
            code_acc_next        = '0;
            if (overlong || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
              err        = 1'b1;
              err_status = u8u16_pkg::STATUS_INVALID;
            end else if (cp <= 21'hFFFF) begin
              push_cmd.bytes[n[1:0]]        = cp[7:0];
              push_cmd.bytes[n[1:0] + 2'd1] = cp[15:8];
              n                             = n + 3'd2;
              push_cmd.last                 = eot;
              if (eot) bom_pending_next = 1'b1;
            end else begin
              // surrogate pair: D800 + high ten bits, DC00 + low ten bits
              s                 = cp - 21'h10000;
              push_cmd.bytes[0] = s[17:10];
              push_cmd.bytes[1] = {6'b110110, s[19:18]};
              push_cmd.bytes[2] = s[7:0];
              push_cmd.bytes[3] = {6'b110111, s[9:8]};
              n                 = 3'd4;
              push_cmd.last     = eot;
              if (eot) bom_pending_next = 1'b1;
            end
          end
        end
      end

      if (err) begin
        bytes_remaining_next   = '0;
        sequence_length_next   = '0;
        code_acc_next          = '0;
        if (eot) begin
          discarding_next  = 1'b0;
          bom_pending_next = 1'b1;
        end else begin
          discarding_next  = 1'b1;
        end
        push_cmd.bytes[n[1:0]] = 8'h00;
        n                      = n + 3'd1;
        push_cmd.status        = err_status;
        push_cmd.last          = 1'b1;
      end
    end

    push_cmd.cnt = n;
  end

  assign push = accept && (push_cmd.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= 1'b0;
      bom_pending     <= 1'b1;
      bytes_remaining <= '0;
      sequence_length <= '0;
      code_acc        <= '0;
      discarding      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) mode <= output_mode;
      if (accept) begin
        bom_pending     <= bom_pending_next;
        bytes_remaining <= bytes_remaining_next;
        sequence_length <= sequence_length_next;
        code_acc        <= code_acc_next;
        discarding      <= discarding_next;
      end
    end
  end

endmodule

// File: src/u8u16_queue.sv
module u8u16_queue #(
  parameter int Depth = u8u16_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            q_valid,
  output u8u16_pkg::cmd_t q_cmd,
  input  logic            pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u8u16_pkg::cmd_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/u8u16_back.sv
module u8u16_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  u8u16_pkg::cmd_t q_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic            last_out
);

  u8u16_pkg::cmd_t cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic            adv;
  logic            final_byte;

  assign adv        = !out_valid || !out_stall;
  assign final_byte = ({1'b0, idx} == cur.cnt - 3'd1);
  // refill the current word as its last byte leaves, so commands run without a gap
  assign pop        = adv && q_valid && (!cur_valid || final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (adv) begin
      if (cur_valid) begin
        out_valid <= 1'b1;
        out_byte  <= cur.bytes[idx];
        status    <= final_byte ? cur.status : u8u16_pkg::STATUS_OK;
        last_out  <= final_byte && cur.last;
        if (final_byte) begin
          cur_valid <= q_valid;
          cur       <= q_cmd;
          idx       <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end else begin
        out_valid <= 1'b0;
        cur_valid <= q_valid;
        cur       <= q_cmd;
        idx       <= '0;
      end
    end
  end

endmodule

// File: src/utf8_to_utf16le_transcoder_core.sv
// An accepted byte passes through the queue, the back end's current-command register and
// the output register before its first output byte appears. Throughput: one output byte per
// cycle while out_stall is low; one input byte per cycle while each makes at most one output
// byte and out_stall is low, otherwise the byte-wide back end holds input back via in_stall.
// Reset (rst, synchronous): pass-through mode, BOM due, decoder idle, queue empty.
module utf8_to_utf16le_transcoder_core #(
  parameter int QueueDepth = u8u16_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       output_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last_out
);

  logic            push;
  u8u16_pkg::cmd_t push_cmd;
  logic            q_full;
  logic            q_valid;
  u8u16_pkg::cmd_t q_cmd;
  logic            pop;

  u8u16_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .output_mode (output_mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .status    (status),
    .last_out  (last_out)
  );

endmodule
